// File: hw/rtl/ibt_pkg.sv
// ----------------------------------------------------------------------------
// ibt_pkg
// Shared types and constants for the interval booking table: field widths,
// status codes, the stored entry layout and the sequencer result word.
// ----------------------------------------------------------------------------
package ibt_pkg;

  localparam int DEFAULT_TABLE_ENTRIES = 64;
  localparam int FIELD_W               = 30;
  localparam int STATUS_W              = 2;

  localparam logic [STATUS_W-1:0] ST_ACCEPT  = 2'd0;
  localparam logic [STATUS_W-1:0] ST_OVERLAP = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL    = 2'd2;

  typedef struct packed {
    logic [FIELD_W-1:0] slot_start;
    logic [FIELD_W-1:0] slot_end;
  } entry_t;

  typedef struct packed {
    logic                done;
    logic [STATUS_W-1:0] status;
  } result_t;

endpackage

// File: hw/rtl/ibt_store.sv
// ----------------------------------------------------------------------------
// ibt_store
// Interval storage: one write port and one read port with registered read
// data, one stored interval per slot.
// ----------------------------------------------------------------------------
module ibt_store #(
  parameter int TABLE_ENTRIES = ibt_pkg::DEFAULT_TABLE_ENTRIES,
  parameter int AW            = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1
) (
  input  logic            clk,
  input  logic            wr_en,
  input  logic [AW-1:0]   wr_addr,
  input  ibt_pkg::entry_t wr_data,
  input  logic            rd_en,
  input  logic [AW-1:0]   rd_addr,
  output ibt_pkg::entry_t rd_data
);
  import ibt_pkg::*;

  entry_t mem [TABLE_ENTRIES];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// File: hw/rtl/ibt_scan.sv
// ----------------------------------------------------------------------------
// ibt_scan
// Request sequencer: latches a request, streams the filled slots out of the
// store one per cycle, folds overlap and duplicate hits, then decides the
// status and appends the interval at the fill count when it is taken.
// ----------------------------------------------------------------------------
module ibt_scan #(
  parameter int TABLE_ENTRIES = ibt_pkg::DEFAULT_TABLE_ENTRIES,
  parameter int AW            = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1,
  parameter int CW            = $clog2(TABLE_ENTRIES + 1)
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [ibt_pkg::FIELD_W-1:0]  interval_start,
  input  logic [ibt_pkg::FIELD_W-1:0]  interval_end,
  input  logic                         out_free,
  output ibt_pkg::result_t             res,
  output logic                         rd_en,
  output logic [AW-1:0]                rd_addr,
  input  ibt_pkg::entry_t              rd_data,
  output logic                         wr_en,
  output logic [AW-1:0]                wr_addr,
  output ibt_pkg::entry_t              wr_data
);
  import ibt_pkg::*;

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_SCAN   = 2'd1;
  localparam logic [1:0] S_DRAIN  = 2'd2;
  localparam logic [1:0] S_DECIDE = 2'd3;

  logic [1:0]         state;
  logic [CW-1:0]      count;
  logic [AW-1:0]      idx;
  logic               cmp_pending;
  logic               clash;
  logic               dup;
  logic [FIELD_W-1:0] req_start;
  logic [FIELD_W-1:0] req_end;
  logic               hit_clash;
  logic               hit_dup;
  logic               table_full;
  logic               insert;
  logic               finish;

  assign in_ready   = (state == S_IDLE);
  assign rd_en      = (state == S_SCAN);
  assign rd_addr    = idx;
  assign table_full = (count == CW'(TABLE_ENTRIES));
  assign finish     = (state == S_DECIDE) && out_free;
  assign insert     = !clash && !dup && !table_full;

  assign hit_clash = cmp_pending &&
                     !((req_start >= rd_data.slot_end) || (req_end <= rd_data.slot_start));
  assign hit_dup   = cmp_pending &&
                     (rd_data.slot_start == req_start) && (rd_data.slot_end == req_end);

  always_comb begin
    res.done = finish;
    if (clash) begin
      res.status = ST_OVERLAP;
    end else if (dup) begin
      res.status = ST_ACCEPT;
    end else if (table_full) begin
      res.status = ST_FULL;
    end else begin
      res.status = ST_ACCEPT;
    end
  end

  assign wr_en              = finish && insert;
  assign wr_addr            = count[AW-1:0];
  assign wr_data.slot_start = req_start;
  assign wr_data.slot_end   = req_end;

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      count       <= '0;
      cmp_pending <= 1'b0;
    end else begin
      cmp_pending <= (state == S_SCAN);
      if (cmp_pending) begin
        clash <= clash | hit_clash;
        dup   <= dup | hit_dup;
      end
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            req_start <= interval_start;
            req_end   <= interval_end;
            clash     <= 1'b0;
            dup       <= 1'b0;
            idx       <= '0;
            state     <= (count == '0) ? S_DECIDE : S_SCAN;
          end
        end
        S_SCAN: begin
          if (CW'(idx) + CW'(1) == count) begin
            state <= S_DRAIN;
          end else begin
            idx <= idx + AW'(1);
          end
        end
        S_DRAIN: begin
          state <= S_DECIDE;
        end
        S_DECIDE: begin
          if (out_free) begin
            if (insert) begin
              count <= count + CW'(1);
            end
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(TABLE_ENTRIES))
    else $error("fill count beyond table capacity");

  a_read_filled: assert property (@(posedge clk) disable iff (rst)
    rd_en |-> (CW'(rd_addr) < count))
    else $error("read of an unfilled slot");

  a_count_step: assert property (@(posedge clk) disable iff (rst)
    (!$past(rst) && (count != $past(count))) |->
      ($past(wr_en) && (count == $past(count) + CW'(1))))
    else $error("fill count moved without an append");

  a_drain_order: assert property (@(posedge clk) disable iff (rst)
    (state == S_DRAIN) |-> cmp_pending)
    else $error("last slot compare missing");

endmodule

// File: hw/rtl/interval_booking_table.sv
// ----------------------------------------------------------------------------
// interval_booking_table
// Table of booked half-open intervals [start, end). A request is stored when
// it overlaps no booked interval, duplicates none and the table has room;
// one status word is returned per request.
//   channel  direction  handshake             word
//   in       sink       in_valid / in_ready   interval_start, interval_end
//   out      source     out_valid / out_ready booking_status
//
// A request sweeps the single read port of the interval store one booked
// slot per cycle; on an empty table the sweep is skipped.
// Reset clears the fill count; stored intervals need no clearing pass.
// A new request is taken while a status word waits on the output; a
// stalled output holds the sequencer in its decide step.
// ----------------------------------------------------------------------------
module interval_booking_table #(
  parameter int TABLE_ENTRIES = ibt_pkg::DEFAULT_TABLE_ENTRIES
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [ibt_pkg::FIELD_W-1:0]   interval_start,
  input  logic [ibt_pkg::FIELD_W-1:0]   interval_end,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [ibt_pkg::STATUS_W-1:0]  booking_status
);
  import ibt_pkg::*;

  localparam int AW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int CW = $clog2(TABLE_ENTRIES + 1);

  logic          out_free;
  result_t       res;
  logic          rd_en;
  logic [AW-1:0] rd_addr;
  entry_t        rd_data;
  logic          wr_en;
  logic [AW-1:0] wr_addr;
  entry_t        wr_data;

  assign out_free = !out_valid || out_ready;

  ibt_scan #(
    .TABLE_ENTRIES (TABLE_ENTRIES),
    .AW            (AW),
    .CW            (CW)
  ) u_scan (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .interval_start (interval_start),
    .interval_end   (interval_end),
    .out_free       (out_free),
    .res            (res),
    .rd_en          (rd_en),
    .rd_addr        (rd_addr),
    .rd_data        (rd_data),
    .wr_en          (wr_en),
    .wr_addr        (wr_addr),
    .wr_data        (wr_data)
  );

  ibt_store #(
    .TABLE_ENTRIES (TABLE_ENTRIES),
    .AW            (AW)
  ) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res.done) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res.done) begin
      booking_status <= res.status;
    end
  end

endmodule
